@@ rtl/wpp_pkg.sv @@
// Shared types and constants for the WAV PCM16 mono stream parser.
package wpp_pkg;

    // One input transfer: a file byte and its end-of-file mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [31:0]        rate;
        logic [30:0]        sample_count;
        logic [2:0]         error_code;
        logic               last_of_run;
    } result_t;

    // Results made by one accepted byte, in order (first, then second).
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_TRUNC  = 3'd0;
    localparam logic [2:0] ERR_RIFF   = 3'd1;
    localparam logic [2:0] ERR_WAVE   = 3'd2;
    localparam logic [2:0] ERR_SHORT  = 3'd3;
    localparam logic [2:0] ERR_UNSUP  = 3'd4;
    localparam logic [2:0] ERR_NORATE = 3'd5;

    // Parser phases; error phases are PH_ERR plus the error code
    localparam logic [3:0] PH_HEADER   = 4'd0;
    localparam logic [3:0] PH_CHUNK    = 4'd1;
    localparam logic [3:0] PH_FMT      = 4'd2;
    localparam logic [3:0] PH_SKIP     = 4'd3;
    localparam logic [3:0] PH_DATA     = 4'd4;
    localparam logic [3:0] PH_ERR      = 4'd8;
    localparam logic [3:0] PH_ERR_LAST = 4'd13;

    // Magic words and chunk ids, little-endian as assembled
    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA    = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [15:0] FMT_MONO    = 16'd1;
    localparam logic [15:0] FMT_BITS16  = 16'd16;

    // Header byte positions
    localparam logic [3:0] POS_RIFF_END  = 4'd3;
    localparam logic [3:0] POS_WAVE_END  = 4'd11;
    localparam logic [3:0] POS_ID_END    = 4'd3;
    localparam logic [3:0] POS_CHDR_END  = 4'd7;
    localparam logic [3:0] POS_FMT_CHAN  = 4'd2;
    localparam logic [3:0] POS_FMT_RATE  = 4'd4;
    localparam logic [3:0] POS_FMT_RSV   = 4'd8;
    localparam logic [3:0] POS_FMT_BITS  = 4'd14;
    localparam logic [3:0] POS_FMT_END   = 4'd15;

    function automatic logic [3:0] err_phase(input logic [2:0] code);
        return {1'b1, code};
    endfunction

endpackage

@@ rtl/wpp_parser.sv @@
// Byte-at-a-time WAV header walker and sample assembler.
module wpp_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  wpp_pkg::in_item_t item,
    output wpp_pkg::push_t    push
);

    logic [3:0]  phase_reg,    phase_next;
    logic [3:0]  pos_reg,      pos_next;
    logic [31:0] id_reg,       id_next;
    logic [31:0] len_reg,      len_next;
    logic [32:0] skip_reg,     skip_next;
    logic [15:0] fmt_reg,      fmt_next;
    logic [15:0] chan_reg,     chan_next;
    logic [15:0] bits_reg,     bits_next;
    logic [31:0] rate_reg,     rate_next;
    logic [31:0] remain_reg,   remain_next;
    logic [7:0]  low_reg,      low_next;
    logic [30:0] count_reg,    count_next;

    logic [7:0]  b;
    logic [31:0] shift_id;
    logic [31:0] shift_len;
    logic [31:0] fmt_rest;
    logic [32:0] skip_calc;
    wpp_pkg::result_t res0, res1, eof_res;
    logic [1:0]  num;

    assign b         = item.data_byte;
    assign shift_id  = {b, id_reg[31:8]};
    assign shift_len = {b, len_reg[31:8]};
    assign fmt_rest  = len_reg - wpp_pkg::FMT_MIN_LEN;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        skip_next   = skip_reg;
        fmt_next    = fmt_reg;
        chan_next   = chan_reg;
        bits_next   = bits_reg;
        rate_next   = rate_reg;
        remain_next = remain_reg;
        low_next    = low_reg;
        count_next  = count_reg;
        skip_calc   = '0;
        res0        = '0;
        res1        = '0;
        eof_res     = '0;
        num         = 2'd0;

        unique case (phase_reg)
            wpp_pkg::PH_HEADER:
            begin
                id_next = shift_id;
                if (pos_reg == wpp_pkg::POS_RIFF_END && shift_id != wpp_pkg::MAGIC_RIFF)
                begin
                    phase_next = wpp_pkg::err_phase(wpp_pkg::ERR_RIFF);
                end
                else if (pos_reg == wpp_pkg::POS_WAVE_END)
                begin
                    if (shift_id != wpp_pkg::MAGIC_WAVE)
                    begin
                        phase_next = wpp_pkg::err_phase(wpp_pkg::ERR_WAVE);
                    end
                    else
                    begin
                        phase_next = wpp_pkg::PH_CHUNK;
                        pos_next   = '0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            wpp_pkg::PH_CHUNK:
            begin
                if (pos_reg <= wpp_pkg::POS_ID_END)
                    id_next = shift_id;
                else
                    len_next = shift_len;
                if (pos_reg == wpp_pkg::POS_CHDR_END)
                begin
                    pos_next = '0;
                    if (id_reg == wpp_pkg::ID_FMT)
                    begin
                        if (shift_len < wpp_pkg::FMT_MIN_LEN)
                            phase_next = wpp_pkg::err_phase(wpp_pkg::ERR_SHORT);
                        else
                            phase_next = wpp_pkg::PH_FMT;
                    end
                    else if (id_reg == wpp_pkg::ID_DATA)
                    begin
                        if (rate_reg == '0)
                        begin
                            phase_next = wpp_pkg::err_phase(wpp_pkg::ERR_NORATE);
                        end
                        else
                        begin
                            phase_next  = wpp_pkg::PH_DATA;
                            remain_next = shift_len;
                            count_next  = '0;
                        end
                    end
                    else
                    begin
                        // unknown chunk: body plus pad byte
                        skip_calc  = {1'b0, shift_len} + 33'(shift_len[0]);
                        skip_next  = skip_calc;
                        phase_next = (skip_calc != '0) ? wpp_pkg::PH_SKIP : wpp_pkg::PH_CHUNK;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            wpp_pkg::PH_FMT:
            begin
                if (pos_reg < wpp_pkg::POS_FMT_CHAN)
                    fmt_next = {b, fmt_reg[15:8]};
                else if (pos_reg < wpp_pkg::POS_FMT_RATE)
                    chan_next = {b, chan_reg[15:8]};
                else if (pos_reg < wpp_pkg::POS_FMT_RSV)
                    rate_next = {b, rate_reg[31:8]};
                else if (pos_reg >= wpp_pkg::POS_FMT_BITS)
                    bits_next = {b, bits_reg[15:8]};
                if (pos_reg == wpp_pkg::POS_FMT_END)
                begin
                    if (fmt_reg != wpp_pkg::FMT_PCM || chan_reg != wpp_pkg::FMT_MONO ||
                        bits_next != wpp_pkg::FMT_BITS16)
                    begin
                        phase_next = wpp_pkg::err_phase(wpp_pkg::ERR_UNSUP);
                    end
                    else
                    begin
                        // rest of a long fmt chunk plus pad byte
                        skip_calc  = {1'b0, fmt_rest} + 33'(len_reg[0]);
                        skip_next  = skip_calc;
                        pos_next   = '0;
                        phase_next = (skip_calc != '0) ? wpp_pkg::PH_SKIP : wpp_pkg::PH_CHUNK;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            wpp_pkg::PH_SKIP:
            begin
                skip_next = skip_reg - 33'd1;
                if (skip_next == '0)
                begin
                    phase_next = wpp_pkg::PH_CHUNK;
                    pos_next   = '0;
                end
            end
            wpp_pkg::PH_DATA:
            begin
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - 32'd1;
                    if (pos_reg == '0)
                    begin
                        low_next = b;
                        pos_next = 4'd1;
                    end
                    else
                    begin
                        res0.kind   = wpp_pkg::KIND_SAMPLE;
                        res0.sample = {b, low_reg};
                        num         = 2'd1;
                        count_next  = count_reg + 31'd1;
                        pos_next    = '0;
                    end
                end
            end
            default:
            begin
                // error phases swallow bytes; unused codes fall into truncated
                if (phase_reg < wpp_pkg::PH_ERR || phase_reg > wpp_pkg::PH_ERR_LAST)
                    phase_next = wpp_pkg::err_phase(wpp_pkg::ERR_TRUNC);
            end
        endcase

        if (item.end_of_file)
        begin
            if (phase_next == wpp_pkg::PH_DATA)
            begin
                eof_res.kind         = wpp_pkg::KIND_DONE;
                eof_res.rate         = rate_next;
                eof_res.sample_count = count_next;
            end
            else if (phase_next >= wpp_pkg::PH_ERR)
            begin
                eof_res.kind       = wpp_pkg::KIND_ERROR;
                eof_res.error_code = phase_next[2:0];
            end
            else
            begin
                eof_res.kind       = wpp_pkg::KIND_ERROR;
                eof_res.error_code = wpp_pkg::ERR_TRUNC;
            end
            eof_res.last_of_run = 1'b1;
            if (num == 2'd1)
                res1 = eof_res;
            else
                res0 = eof_res;
            num = num + 2'd1;

            // fresh start for the next file
            phase_next  = wpp_pkg::PH_HEADER;
            pos_next    = '0;
            id_next     = '0;
            len_next    = '0;
            skip_next   = '0;
            fmt_next    = '0;
            chan_next   = '0;
            bits_next   = '0;
            rate_next   = '0;
            remain_next = '0;
            low_next    = '0;
            count_next  = '0;
        end
        else if (num == 2'd1)
        begin
            res0.last_of_run = 1'b1;
        end
    end

    assign push.num    = take ? num : 2'd0;
    assign push.first  = res0;
    assign push.second = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wpp_pkg::PH_HEADER;
            pos_reg    <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            skip_reg   <= '0;
            fmt_reg    <= '0;
            chan_reg   <= '0;
            bits_reg   <= '0;
            rate_reg   <= '0;
            remain_reg <= '0;
            low_reg    <= '0;
            count_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            skip_reg   <= skip_next;
            fmt_reg    <= fmt_next;
            chan_reg   <= chan_next;
            bits_reg   <= bits_next;
            rate_reg   <= rate_next;
            remain_reg <= remain_next;
            low_reg    <= low_next;
            count_reg  <= count_next;
        end
    end

    // two results only when a byte ends the file
    a_two_only_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> (take && item.end_of_file))
        else $error("two results without end of file");

    // end of file restarts the walk
    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.end_of_file) |=> (phase_reg == wpp_pkg::PH_HEADER && count_reg == '0))
        else $error("parser did not restart after end of file");

    // data body is reached only with a known rate
    a_data_has_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wpp_pkg::PH_DATA) |-> (rate_reg != '0))
        else $error("data phase with zero rate");

endmodule

@@ rtl/wpp_out_fifo.sv @@
// Result queue: takes up to two results a cycle, delivers one while head_ready is high.
module wpp_out_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wpp_pkg::push_t   push,
    output logic             space_ok,
    output logic             head_valid,
    input  logic             head_ready,
    output wpp_pkg::result_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wpp_pkg::result_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_p1  = ptr_inc(wr_ptr_reg);
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && head_ready;
    assign head       = slot_reg[rd_ptr_reg];
    // room for a worst-case pair regardless of a pop this cycle
    assign space_ok   = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.num == 2'd1)
            wr_ptr_next = wr_ptr_p1;
        else if (push.num == 2'd2)
            wr_ptr_next = ptr_inc(wr_ptr_p1);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push.num != 2'd0 && PTR_W'(i) == wr_ptr_reg)
                slot_reg[i] <= push.first;
            else if (push.num == 2'd2 && PTR_W'(i) == wr_ptr_p1)
                slot_reg[i] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> ((int'(count_reg) + int'(push.num)) <= DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("result queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.num == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop without push did not drain one entry");

endmodule

@@ rtl/wav_pcm16_mono_stream_parser.sv @@
// Top level of the WAV PCM16 mono byte-stream parser.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  byte     | byte_valid / byte_ready     | byte_data   (data_byte, end_of_file)
//  result   | result_valid / result_ready | result_data (kind, sample, rate,
//           |                             |   sample_count, error_code,
//           |                             |   last_of_run)
//
// One byte per cycle while byte_ready is high. Each accepted byte updates the
// parser registers in the same cycle and its results (at most two: a sample and
// the end-of-file report) land in the result queue, visible in the next cycle.
// byte_ready drops only when the queue has fewer than two free entries, so
// a stalled result side holds off input after FIFO_DEPTH-1 pending results.
// Reset (rst_n, async) puts the parser at the start of a file and empties
// the queue.
module wav_pcm16_mono_stream_parser
#(
    parameter int FIFO_DEPTH = 4    // result queue entries, 2 or more
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  wpp_pkg::in_item_t byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output wpp_pkg::result_t  result_data
);

    logic           take;
    logic           space_ok;
    wpp_pkg::push_t push;

    assign byte_ready = space_ok;
    assign take       = byte_valid && byte_ready;

    // header walk, chunk skip and sample assembly
    wpp_parser u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_data),
        .push  (push)
    );

    // decouples the result side from the byte side
    wpp_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head_valid (result_valid),
        .head_ready (result_ready),
        .head       (result_data)
    );

endmodule
